// ===== src/fog_range_adjust_table_gen_assert.svh =====
// assertion macros for the fog range adjust table generator
// expects clk and rst in the scope of the module that uses them
`ifndef FOG_RANGE_ADJUST_TABLE_GEN_ASSERT_SVH
`define FOG_RANGE_ADJUST_TABLE_GEN_ASSERT_SVH

// same-cycle implication
`define FRAT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("frat assertion failed");

// next-cycle implication
`define FRAT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frat assertion failed");

`endif

// ===== src/frat_pkg.sv =====
// shared constants, types and saturation helpers of the fog range adjust table generator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package frat_pkg;

  localparam int TABLE_ENTRIES = 10;
  localparam int CNT_W = (TABLE_ENTRIES > 16) ? 5 : 4;
  localparam int DIV_W = 48;
  localparam int DSR_W = 36;
  localparam int SQ_STEPS = 24;
  localparam int SQ_W = 48;
  localparam logic signed [31:0] SQRT3_Q16 = 32'sd113512;
  localparam logic signed [31:0] FIX_ONE = 32'sd65536;
  localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] Q_MIN = 32'sh80000000;

  typedef struct packed {
    logic                persp;
    logic signed [31:0]  m00;
    logic signed [31:0]  near1;
    logic                q_neg;
    logic                dz;
    logic                n_neg;
    logic                n_zero;
    logic                unity;
    logic [DSR_W-1:0]    dd;
  } frat_side_t;

  typedef struct packed {
    logic [DIV_W-1:0] qb;
    logic [DSR_W-1:0] rb;
    logic [DSR_W-1:0] dd;
    logic             unity;
  } frat_setup_t;

  function automatic logic [31:0] abs32(input logic signed [31:0] x);
    logic [31:0] r;
    r = x[31] ? (32'd0 - 32'(x)) : 32'(x);
    return r;
  endfunction

  // signed result from magnitude and sign, clamped to 32 bits
  function automatic logic signed [31:0] sat_q(input logic [DIV_W-1:0] mag,
                                               input logic q_neg, input logic dz,
                                               input logic n_neg, input logic n_zero);
    logic signed [31:0] r;
    if (dz) begin
      r = n_zero ? 32'sd0 : (n_neg ? Q_MIN : Q_MAX);
    end else if (!q_neg) begin
      r = (mag > DIV_W'(32'h7fffffff)) ? Q_MAX : signed'(mag[31:0]);
    end else begin
      r = (mag > DIV_W'(32'h80000000)) ? Q_MIN : signed'(32'd0 - mag[31:0]);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/frat_if.sv =====
// channel interfaces of the fog range adjust table generator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface frat_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] proj_m00;
  logic signed [31:0] proj_m22;
  logic signed [31:0] proj_m23;
  logic signed [31:0] proj_m33;
  logic [15:0]        screen_width;
  modport source (output valid, output proj_m00, output proj_m22, output proj_m23,
                  output proj_m33, output screen_width, input ready);
  modport sink (input valid, input proj_m00, input proj_m22, input proj_m23,
                input proj_m33, input screen_width, output ready);
endinterface

interface frat_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  entry_index;
  logic [11:0] adj_value;
  logic        last_entry;
  modport source (output valid, output entry_index, output adj_value, output last_entry,
                  input ready);
  modport sink (input valid, input entry_index, input adj_value, input last_entry,
                output ready);
endinterface

`default_nettype wire

// ===== src/frat_div_pipe.sv =====
// pipelined unsigned restoring divider, one quotient bit per stage
// depends on frat_pkg
`timescale 1ns / 1ps
`default_nettype none

module frat_div_pipe (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            en,
  input  wire                            in_vld,
  input  wire [frat_pkg::DIV_W-1:0]      dividend,
  input  wire [frat_pkg::DSR_W-1:0]      divisor,
  input  frat_pkg::frat_side_t           side_in,
  output logic                           out_vld,
  output logic [frat_pkg::DIV_W-1:0]     quo,
  output logic [frat_pkg::DSR_W-1:0]     rem,
  output frat_pkg::frat_side_t           side_out
);

  localparam int N = frat_pkg::DIV_W;
  localparam int D = frat_pkg::DSR_W;

  logic                 vld [0:N];
  logic [D-1:0]         rm  [0:N];
  logic [N-1:0]         dq  [0:N];
  logic [D-1:0]         ds  [0:N];
  frat_pkg::frat_side_t sb  [0:N];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rm[0] <= '0;
      dq[0] <= dividend;
      ds[0] <= divisor;
      sb[0] <= side_in;
    end
  end

  for (genvar s = 1; s <= N; s++) begin : g_stage
    logic [D:0] sh;
    logic [D:0] df;
    logic       ge;
    // partial remainder with the next dividend bit shifted in
    assign sh = {rm[s-1], dq[s-1][N-1]};
    assign df = sh - {1'b0, ds[s-1]};
    assign ge = sh >= {1'b0, ds[s-1]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s] <= vld[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rm[s] <= ge ? df[D-1:0] : sh[D-1:0];
        dq[s] <= {dq[s-1][N-2:0], ge};
        ds[s] <= ds[s-1];
        sb[s] <= sb[s-1];
      end
    end
  end

  assign out_vld  = vld[N];
  assign quo      = dq[N];
  assign rem      = rm[N];
  assign side_out = sb[N];

endmodule

`default_nettype wire

// ===== src/frat_setup.sv =====
// per-item setup: near distance, side extent and the base step quotient
// depends on frat_pkg, frat_if, frat_div_pipe
`timescale 1ns / 1ps
`default_nettype none

module frat_setup (
  input  wire                    clk,
  input  wire                    rst,
  frat_in_if.sink                item_in,
  output logic                   f_vld,
  output frat_pkg::frat_setup_t  f_data,
  input  wire                    f_rdy
);

  logic en;
  logic d3_vld;
  assign en = !(d3_vld && !f_rdy);
  assign item_in.ready = en;

  // input register
  logic               a_vld;
  logic signed [31:0] a_m00, a_m22, a_m23, a_m33;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (en) begin
      a_vld <= item_in.valid && (item_in.screen_width != 16'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_m00 <= item_in.proj_m00;
      a_m22 <= item_in.proj_m22;
      a_m23 <= item_in.proj_m23;
      a_m33 <= item_in.proj_m33;
    end
  end

  // near = m23 / (m22 - 1)
  logic [32:0]              den1, den1_mag;
  frat_pkg::frat_side_t     sb1_in, sb1_out;
  logic                     d1_vld;
  logic [frat_pkg::DIV_W-1:0] d1_q;
  logic [frat_pkg::DSR_W-1:0] d1_r;

  assign den1     = {a_m22[31], a_m22} - 33'd65536;
  assign den1_mag = den1[32] ? (33'd0 - den1) : den1;

  always_comb begin
    sb1_in        = '0;
    sb1_in.persp  = (a_m33 == 32'sd0);
    sb1_in.m00    = a_m00;
    sb1_in.q_neg  = a_m23[31] ^ den1[32];
    sb1_in.dz     = (den1 == 33'd0);
    sb1_in.n_neg  = a_m23[31];
    sb1_in.n_zero = (a_m23 == 32'sd0);
  end

  frat_div_pipe u_div1 (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (a_vld),
    .dividend ({frat_pkg::abs32(a_m23), 16'h0}),
    .divisor  ({3'b0, den1_mag}),
    .side_in  (sb1_in),
    .out_vld  (d1_vld),
    .quo      (d1_q),
    .rem      (d1_r),
    .side_out (sb1_out)
  );

  logic                 b_vld;
  frat_pkg::frat_side_t b_sb, b_sb_next;

  always_comb begin
    b_sb_next       = sb1_out;
    b_sb_next.near1 = frat_pkg::sat_q(d1_q, sb1_out.q_neg, sb1_out.dz, sb1_out.n_neg,
                                      sb1_out.n_zero);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else if (en) begin
      b_vld <= d1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_sb <= b_sb_next;
    end
  end

  // side = near / m00 in perspective, 1 / m00 otherwise
  frat_pkg::frat_side_t       sb2_in, sb2_out;
  logic [frat_pkg::DIV_W-1:0] num2;
  logic                       d2_vld;
  logic [frat_pkg::DIV_W-1:0] d2_q;
  logic [frat_pkg::DSR_W-1:0] d2_r;

  always_comb begin
    sb2_in        = b_sb;
    sb2_in.n_neg  = b_sb.persp && b_sb.near1[31];
    sb2_in.n_zero = b_sb.persp && (b_sb.near1 == 32'sd0);
    sb2_in.q_neg  = sb2_in.n_neg ^ b_sb.m00[31];
    sb2_in.dz     = (b_sb.m00 == 32'sd0);
    num2 = b_sb.persp ? {frat_pkg::abs32(b_sb.near1), 16'h0} : 48'h0001_0000_0000;
  end

  frat_div_pipe u_div2 (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (b_vld),
    .dividend (num2),
    .divisor  ({4'b0, frat_pkg::abs32(b_sb.m00)}),
    .side_in  (sb2_in),
    .out_vld  (d2_vld),
    .quo      (d2_q),
    .rem      (d2_r),
    .side_out (sb2_out)
  );

  logic                 c_vld, d_vld, e_vld;
  frat_pkg::frat_side_t c_sb, d_sb, e_sb;
  logic signed [31:0]   c_side, d_side, e_near;
  logic signed [49:0]   d_prod;
  logic [31:0]          e_aside;
  logic [49:0]          prod_mag;
  logic [frat_pkg::DIV_W-1:0] prod_q;

  // truncate toward zero: shift the magnitude
  assign prod_mag = d_prod[49] ? (50'd0 - 50'(d_prod)) : 50'(d_prod);
  assign prod_q   = {15'b0, prod_mag[48:16]};

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
      d_vld <= 1'b0;
      e_vld <= 1'b0;
    end else if (en) begin
      c_vld <= d2_vld;
      d_vld <= c_vld;
      e_vld <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_sb    <= sb2_out;
      c_side  <= frat_pkg::sat_q(d2_q, sb2_out.q_neg, sb2_out.dz, sb2_out.n_neg,
                                 sb2_out.n_zero);
      d_sb    <= c_sb;
      d_side  <= c_side;
      d_prod  <= 50'(c_side) * 50'(frat_pkg::SQRT3_Q16);
      e_sb    <= d_sb;
      e_aside <= frat_pkg::abs32(d_side);
      e_near  <= d_sb.persp ? d_sb.near1 : frat_pkg::sat_q(prod_q, d_prod[49], 1'b0, 1'b0,
                                                           1'b0);
    end
  end

  // base step = |side| / (10 * near)
  frat_pkg::frat_side_t       sb3_in, sb3_out;
  logic [frat_pkg::DSR_W-1:0] den3;
  logic [frat_pkg::DIV_W-1:0] d3_q;
  logic [frat_pkg::DSR_W-1:0] d3_r;

  assign den3 = ({5'b0, e_near[30:0]} << 3) + ({5'b0, e_near[30:0]} << 1);

  always_comb begin
    sb3_in       = e_sb;
    sb3_in.unity = e_near[31] || (e_near == 32'sd0);
    sb3_in.dd    = den3;
  end

  frat_div_pipe u_div3 (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (e_vld),
    .dividend ({e_aside, 16'h0}),
    .divisor  (den3),
    .side_in  (sb3_in),
    .out_vld  (d3_vld),
    .quo      (d3_q),
    .rem      (d3_r),
    .side_out (sb3_out)
  );

  assign f_vld        = d3_vld;
  assign f_data.qb    = d3_q;
  assign f_data.rb    = d3_r;
  assign f_data.dd    = sb3_out.dd;
  assign f_data.unity = sb3_out.unity;

endmodule

`default_nettype wire

// ===== src/frat_entries.sv =====
// entry sequencer, squaring stage and pipelined integer square root
// depends on frat_pkg, frat_if and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none
`include "fog_range_adjust_table_gen_assert.svh"

module frat_entries (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    s_vld,
  input  frat_pkg::frat_setup_t  s_data,
  output logic                   s_rdy,
  frat_out_if.source             entry_out
);

  localparam int CW = frat_pkg::CNT_W;
  localparam int NS = frat_pkg::SQ_STEPS;
  localparam int SW = frat_pkg::SQ_W;
  localparam logic [CW-1:0] LAST = CW'(frat_pkg::TABLE_ENTRIES - 1);

  logic o_vld, o_last, en;
  logic [CW-1:0] o_idx;
  assign en = !(o_vld && !entry_out.ready);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [49:0]   qacc, qacc_next;
  logic [35:0]   racc, racc_next;
  logic [47:0]   cur_qb;
  logic [35:0]   cur_rb, cur_dd;
  logic          cur_unity;
  logic [36:0]   rsum, rsub;
  logic          rge;
  logic [30:0]   qsat;

  assign s_rdy = en && (!busy || (cnt == LAST));

  // (k+1)*A/D from k*A/D: add base quotient and remainder, fix up once
  assign rsum      = {1'b0, racc} + {1'b0, cur_rb};
  assign rge       = rsum >= {1'b0, cur_dd};
  assign rsub      = rsum - {1'b0, cur_dd};
  assign racc_next = rge ? rsub[35:0] : rsum[35:0];
  assign qacc_next = qacc + {2'b0, cur_qb} + {49'b0, rge};
  assign qsat      = cur_unity ? 31'd0 :
                     ((qacc > 50'h7fffffff) ? 31'h7fffffff : qacc[30:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (en) begin
      if (s_vld && s_rdy) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == LAST) begin
          busy <= 1'b0;
        end else begin
          cnt <= cnt + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (s_vld && s_rdy) begin
        cur_qb    <= s_data.qb;
        cur_rb    <= s_data.rb;
        cur_dd    <= s_data.dd;
        cur_unity <= s_data.unity;
        qacc      <= {2'b0, s_data.qb};
        racc      <= s_data.rb;
      end else if (busy) begin
        qacc <= qacc_next;
        racc <= racc_next;
      end
    end
  end

  // issue and square
  logic          p1_vld, p2_vld, p1_last, p2_last;
  logic [CW-1:0] p1_idx, p2_idx;
  logic [30:0]   p1_q;
  logic [61:0]   p2_qq;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_vld <= 1'b0;
      p2_vld <= 1'b0;
    end else if (en) begin
      p1_vld <= busy;
      p2_vld <= p1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_idx  <= cnt;
      p1_last <= (cnt == LAST);
      p1_q    <= qsat;
      p2_idx  <= p1_idx;
      p2_last <= p1_last;
      p2_qq   <= 62'(p1_q) * 62'(p1_q);
    end
  end

  // square root, one result bit per stage
  logic          sq_vld [0:NS];
  logic          sq_lst [0:NS];
  logic [CW-1:0] sq_idx [0:NS];
  logic [SW-1:0] sq_rm  [0:NS];
  logic [NS-1:0] sq_rt  [0:NS];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_vld[0] <= 1'b0;
    end else if (en) begin
      sq_vld[0] <= p2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_lst[0] <= p2_last;
      sq_idx[0] <= p2_idx;
      sq_rm[0]  <= {2'b0, p2_qq[61:16]} + SW'(65536);
      sq_rt[0]  <= '0;
    end
  end

  for (genvar s = 1; s <= NS; s++) begin : g_sq
    localparam int J = NS - s;
    logic [SW-1:0] test;
    logic          ge;
    // (r + 2^j)^2 - r^2
    assign test = ({{(SW-NS){1'b0}}, sq_rt[s-1]} << (J + 1)) + (SW'(1) << (2 * J));
    assign ge   = sq_rm[s-1] >= test;

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_vld[s] <= 1'b0;
      end else if (en) begin
        sq_vld[s] <= sq_vld[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_lst[s] <= sq_lst[s-1];
        sq_idx[s] <= sq_idx[s-1];
        sq_rm[s]  <= ge ? (sq_rm[s-1] - test) : sq_rm[s-1];
        sq_rt[s]  <= ge ? (sq_rt[s-1] | (NS'(1) << J)) : sq_rt[s-1];
      end
    end
  end

  assign o_vld  = sq_vld[NS];
  assign o_last = sq_lst[NS];
  assign o_idx  = sq_idx[NS];

  assign entry_out.valid       = o_vld;
  assign entry_out.entry_index = o_idx[3:0];
  assign entry_out.adj_value   = sq_rt[NS][11:0];
  assign entry_out.last_entry  = o_last;

  `FRAT_ASSERT_IMP(a_last_idx, o_vld && o_last, o_idx == LAST)
  `FRAT_ASSERT_NXT(a_stall_hold, busy && !en, busy && $stable(cnt) && $stable(qacc))
  `FRAT_ASSERT_NXT(a_count_step, busy && en && (cnt != LAST), busy && (cnt == $past(cnt) + CW'(1)))
  `FRAT_ASSERT_IMP(a_rem_bound, busy && !cur_unity, racc < cur_dd)

endmodule

`default_nettype wire

// ===== src/fog_range_adjust_table_gen.sv =====
// fog range adjustment table generator
// item_in takes projection terms and a screen width; entry_out gives the table entries.
// each accepted item with a nonzero width yields TABLE_ENTRIES entries (ten), index 0
// first, the last one flagged by last_entry; a zero width yields nothing.
// adj_value is floor(256*sqrt(1+(x/near)^2)) in 12 bits, 256 meaning 1.0.
// an accepted item runs through three 48-stage divider pipelines, the glue registers
// a to e, the entry sequencer, the p1 and p2 registers and a 24-stage square root.
// throughput: one entry per cycle unless entry_out stalls, set by the entry sequencer
// that issues one entry a cycle; items are taken every cycle while the setup
// pipeline has room and queue up behind the sequencer.
// an entry waiting on entry_out.ready holds the pipeline; none is lost or repeated.
// reset (rst, synchronous, active high) clears all valid bits and the sequencer,
// and item_in.ready is high in the first cycle after it.
// depends on frat_pkg, frat_if, frat_setup, frat_entries
`timescale 1ns / 1ps
`default_nettype none

module fog_range_adjust_table_gen (
  input  wire         clk,
  input  wire         rst,
  frat_in_if.sink     item_in,
  frat_out_if.source  entry_out
);

  logic                  s_vld;
  logic                  s_rdy;
  frat_pkg::frat_setup_t s_data;

  frat_setup u_setup (
    .clk     (clk),
    .rst     (rst),
    .item_in (item_in),
    .f_vld   (s_vld),
    .f_data  (s_data),
    .f_rdy   (s_rdy)
  );

  frat_entries u_entries (
    .clk       (clk),
    .rst       (rst),
    .s_vld     (s_vld),
    .s_data    (s_data),
    .s_rdy     (s_rdy),
    .entry_out (entry_out)
  );

endmodule

`default_nettype wire
